// ----- rtl/bezier_path_flattener_defines.svh -----
// Assertion macros used by the flattener engine module.
`ifndef BEZIER_PATH_FLATTENER_DEFINES_SVH
`define BEZIER_PATH_FLATTENER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BPF_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BPF_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/bpf_pkg.sv -----
package bpf_pkg;

    // Coordinate format: signed fixed point with 4 fraction bits.
    localparam int COORD_WIDTH     = 20;
    localparam int DIFF_WIDTH      = COORD_WIDTH + 1;
    localparam int PROD_WIDTH      = 2 * DIFF_WIDTH;
    localparam int CROSS_WIDTH     = PROD_WIDTH + 1;
    localparam int DIST_WIDTH      = CROSS_WIDTH + 1;
    localparam int LEN_WIDTH       = PROD_WIDTH + 1;
    localparam int TOL_WIDTH       = 16;
    localparam int FLAT_LIMIT_BITS = 42;
    localparam int SPLIT_LO        = 32;
    localparam int DHI_WIDTH       = FLAT_LIMIT_BITS - SPLIT_LO;
    localparam int LHI_WIDTH       = LEN_WIDTH - SPLIT_LO;
    localparam int CMP_WIDTH       = 2 * FLAT_LIMIT_BITS;

    localparam int DEFAULT_MAX_DEPTH = 5;
    localparam logic [TOL_WIDTH-1:0] TOL_RESET = 16'd64;

    // Input command codes.
    typedef enum logic [1:0] {
        ACT_MOVE  = 2'd0,
        ACT_LINE  = 2'd1,
        ACT_QUAD  = 2'd2,
        ACT_CUBIC = 2'd3
    } action_t;

    // Result kind codes.
    localparam logic [1:0] KIND_POINT = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // Work handed from the front to the back.
    typedef enum logic [1:0] {
        OP_EMIT  = 2'd0,
        OP_QUAD  = 2'd1,
        OP_CUBIC = 2'd2
    } op_t;

    typedef struct packed {
        logic [COORD_WIDTH-1:0] x;
        logic [COORD_WIDTH-1:0] y;
    } point_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] kind;
        point_t     p0;
        point_t     p1;
        point_t     p2;
        point_t     p3;
    } cmd_t;

    // Midpoint rounded toward minus infinity.
    function automatic logic [COORD_WIDTH-1:0] half_floor(
        input logic [COORD_WIDTH-1:0] a,
        input logic [COORD_WIDTH-1:0] b
    );
        logic [COORD_WIDTH:0] s;
        s = {a[COORD_WIDTH-1], a} + {b[COORD_WIDTH-1], b};
        return s[COORD_WIDTH:1];
    endfunction

    function automatic point_t mid_pt(input point_t a, input point_t b);
        point_t r;
        r.x = half_floor(a.x, b.x);
        r.y = half_floor(a.y, b.y);
        return r;
    endfunction

    // Signed difference of two coordinates.
    function automatic logic signed [DIFF_WIDTH-1:0] coord_diff(
        input logic [COORD_WIDTH-1:0] a,
        input logic [COORD_WIDTH-1:0] b
    );
        return $signed({a[COORD_WIDTH-1], a}) - $signed({b[COORD_WIDTH-1], b});
    endfunction

endpackage

// ----- rtl/bpf_front.sv -----
module bpf_front
    import bpf_pkg::*;
(
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_action,
    input  logic signed [COORD_WIDTH-1:0] s_ax,
    input  logic signed [COORD_WIDTH-1:0] s_ay,
    input  logic signed [COORD_WIDTH-1:0] s_bx,
    input  logic signed [COORD_WIDTH-1:0] s_by,
    input  logic signed [COORD_WIDTH-1:0] s_cx,
    input  logic signed [COORD_WIDTH-1:0] s_cy,
    output logic                          push_valid,
    input  logic                          push_ready,
    output cmd_t                          push_cmd
);

    logic [COORD_WIDTH-1:0] last_x_reg, last_y_reg;
    logic                   move_pending_reg;
    logic                   accept;
    logic                   line_same;
    point_t                 pa, pb, pc, plast;

    assign s_ready = push_ready;
    assign accept  = s_valid && s_ready;

    assign pa    = '{x: s_ax, y: s_ay};
    assign pb    = '{x: s_bx, y: s_by};
    assign pc    = '{x: s_cx, y: s_cy};
    assign plast = '{x: last_x_reg, y: last_y_reg};

    assign line_same = (pa == plast);

    // Classify the incoming transaction into a command for the back end.
    always_comb begin
        push_cmd.op   = OP_EMIT;
        push_cmd.kind = KIND_POINT;
        push_cmd.p0   = pa;
        push_cmd.p1   = pa;
        push_cmd.p2   = pb;
        push_cmd.p3   = pc;
        push_valid    = s_valid;
        case (action_t'(s_action))
            ACT_MOVE: begin
                if (move_pending_reg) begin
                    push_cmd.kind = KIND_ERROR;
                    push_cmd.p0   = '0;
                end else begin
                    push_cmd.kind = KIND_START;
                end
            end
            ACT_LINE: begin
                push_valid = s_valid && !line_same;
            end
            ACT_QUAD: begin
                push_cmd.op = OP_QUAD;
                push_cmd.p0 = plast;
                push_cmd.p3 = pb;
            end
            default: begin
                push_cmd.op = OP_CUBIC;
                push_cmd.p0 = plast;
            end
        endcase
    end

    // Current point and subpath tracking.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_x_reg       <= '0;
            last_y_reg       <= '0;
            move_pending_reg <= 1'b0;
        end else if (accept) begin
            case (action_t'(s_action))
                ACT_MOVE: begin
                    if (!move_pending_reg) begin
                        last_x_reg       <= pa.x;
                        last_y_reg       <= pa.y;
                        move_pending_reg <= 1'b1;
                    end
                end
                ACT_LINE: begin
                    if (!line_same) begin
                        last_x_reg       <= pa.x;
                        last_y_reg       <= pa.y;
                        move_pending_reg <= 1'b0;
                    end
                end
                ACT_QUAD: begin
                    last_x_reg       <= pb.x;
                    last_y_reg       <= pb.y;
                    move_pending_reg <= 1'b0;
                end
                default: begin
                    last_x_reg       <= pc.x;
                    last_y_reg       <= pc.y;
                    move_pending_reg <= 1'b0;
                end
            endcase
        end
    end

endmodule

// ----- rtl/bpf_cmd_queue.sv -----
module bpf_cmd_queue
    import bpf_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  cmd_t in_cmd,
    output logic out_valid,
    input  logic out_pop,
    output cmd_t out_cmd
);

    // Two-entry queue between the front and the back.
    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push, pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_cmd   = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_pop && out_valid;

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// ----- rtl/bpf_engine.sv -----
`include "bezier_path_flattener_defines.svh"

module bpf_engine
    import bpf_pkg::*;
#(
    parameter int MAX_DEPTH = DEFAULT_MAX_DEPTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    output logic                          q_pop,
    input  cmd_t                          q_cmd,
    input  logic [TOL_WIDTH-1:0]          tolerance,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [COORD_WIDTH-1:0] m_out_x,
    output logic signed [COORD_WIDTH-1:0] m_out_y,
    output logic [1:0]                    m_kind,
    output logic                          m_last
);

    localparam int LVW  = $clog2(MAX_DEPTH + 1);
    localparam int CNTW = $clog2(MAX_DEPTH + 1);
    localparam int SIW  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    typedef struct packed {
        point_t          p0;
        point_t          p1;
        point_t          p2;
        point_t          p3;
        logic [LVW-1:0]  level;
    } piece_t;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_PROD   = 5'b00010,
        S_PART   = 5'b00100,
        S_DECIDE = 5'b01000,
        S_END    = 5'b10000
    } state_t;

    state_t          state_reg, state_next;
    piece_t          piece_reg;
    piece_t          stack_mem [MAX_DEPTH];
    logic [CNTW-1:0] sp_reg;
    logic            is_cubic_reg;
    point_t          endpt_reg;

    logic                         m_valid_reg, m_last_reg;
    logic [COORD_WIDTH-1:0]       m_x_reg, m_y_reg;
    logic [1:0]                   m_kind_reg;

    // Flatness test pipeline registers.
    logic signed [PROD_WIDTH-1:0] pa1_reg, pb1_reg, pa2_reg, pb2_reg, sqx_reg, sqy_reg;
    logic [2*SPLIT_LO-1:0]              ll_reg;
    logic [DHI_WIDTH+SPLIT_LO-1:0]      hl_reg;
    logic [2*DHI_WIDTH-1:0]             hh_reg;
    logic [SPLIT_LO+TOL_WIDTH-1:0]      rl_reg;
    logic [LHI_WIDTH+TOL_WIDTH-1:0]     rh_reg;
    logic                               in_range_reg;

    // Piece geometry, valid while the piece register holds.
    point_t piece_end;
    logic signed [DIFF_WIDTH-1:0] u1x, u1y, u2x, u2y, vx, vy;
    point_t m12, m23, m34, m123, m234, m1234, leaf_mid;

    assign piece_end = is_cubic_reg ? piece_reg.p3 : piece_reg.p2;
    assign u1x = coord_diff(piece_reg.p1.x, piece_end.x);
    assign u1y = coord_diff(piece_reg.p1.y, piece_end.y);
    assign u2x = coord_diff(piece_reg.p2.x, piece_end.x);
    assign u2y = coord_diff(piece_reg.p2.y, piece_end.y);
    assign vx  = coord_diff(piece_end.x, piece_reg.p0.x);
    assign vy  = coord_diff(piece_end.y, piece_reg.p0.y);

    assign m12      = mid_pt(piece_reg.p0, piece_reg.p1);
    assign m23      = mid_pt(piece_reg.p1, piece_reg.p2);
    assign m34      = mid_pt(piece_reg.p2, piece_reg.p3);
    assign m123     = mid_pt(m12, m23);
    assign m234     = mid_pt(m23, m34);
    assign m1234    = mid_pt(m123, m234);
    assign leaf_mid = is_cubic_reg ? m1234 : m123;

    // Second step: cross magnitudes, distance sum and partial products.
    logic signed [CROSS_WIDTH-1:0] c1, c2;
    logic [CROSS_WIDTH-1:0]        a1, a2;
    logic [DIST_WIDTH-1:0]         dist_sum;
    logic [LEN_WIDTH-1:0]          len;
    logic [SPLIT_LO-1:0]           d_lo;
    logic [DHI_WIDTH-1:0]          d_hi;

    assign c1   = CROSS_WIDTH'(pa1_reg) - CROSS_WIDTH'(pb1_reg);
    assign c2   = CROSS_WIDTH'(pa2_reg) - CROSS_WIDTH'(pb2_reg);
    assign a1   = c1[CROSS_WIDTH-1] ? (CROSS_WIDTH'(0) - c1) : c1;
    assign a2   = c2[CROSS_WIDTH-1] ? (CROSS_WIDTH'(0) - c2) : c2;
    assign dist_sum = DIST_WIDTH'(a1) + DIST_WIDTH'(a2);
    assign len  = LEN_WIDTH'($unsigned(sqx_reg)) + LEN_WIDTH'($unsigned(sqy_reg));
    assign d_lo = dist_sum[SPLIT_LO-1:0];
    assign d_hi = dist_sum[FLAT_LIMIT_BITS-1:SPLIT_LO];

    // Third step: recombine and compare.
    logic [CMP_WIDTH-1:0] dd, rhs;
    logic                 flat;

    assign dd  = (CMP_WIDTH'(hh_reg) << (2 * SPLIT_LO))
               + (CMP_WIDTH'(hl_reg) << (SPLIT_LO + 1))
               + CMP_WIDTH'(ll_reg);
    assign rhs = (CMP_WIDTH'(rh_reg) << SPLIT_LO) + CMP_WIDTH'(rl_reg);
    assign flat = in_range_reg && (dd < rhs);

    // Control decisions.
    logic            out_free, can_split, emit_leaf, split, advance, m_load;
    logic [SIW-1:0]  push_idx, top_idx;
    piece_t          left_piece, right_piece;

    assign out_free  = !m_valid_reg || m_ready;
    assign can_split = (piece_reg.level < LVW'(MAX_DEPTH));
    assign emit_leaf = (state_reg == S_DECIDE) && flat && out_free;
    assign split     = (state_reg == S_DECIDE) && !flat && can_split;
    assign advance   = emit_leaf || ((state_reg == S_DECIDE) && !flat && !can_split);
    assign q_pop     = (state_reg == S_IDLE) && q_valid && ((q_cmd.op != OP_EMIT) || out_free);
    assign push_idx  = sp_reg[SIW-1:0];
    assign top_idx   = SIW'(sp_reg - CNTW'(1));

    // A new result enters the output register.
    assign m_load    = (q_pop && (q_cmd.op == OP_EMIT)) || emit_leaf
                     || ((state_reg == S_END) && out_free);

    always_comb begin
        left_piece       = piece_reg;
        left_piece.p1    = m12;
        left_piece.p2    = m123;
        left_piece.p3    = m1234;
        left_piece.level = piece_reg.level + LVW'(1);
        right_piece       = piece_reg;
        right_piece.level = piece_reg.level + LVW'(1);
        if (is_cubic_reg) begin
            right_piece.p0 = m1234;
            right_piece.p1 = m234;
            right_piece.p2 = m34;
        end else begin
            right_piece.p0 = m123;
            right_piece.p1 = m23;
        end
    end

    // Sequencer for one command.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (q_pop && (q_cmd.op != OP_EMIT)) begin
                    state_next = S_PROD;
                end
            end
            S_PROD: begin
                state_next = S_PART;
            end
            S_PART: begin
                state_next = S_DECIDE;
            end
            S_DECIDE: begin
                if (split) begin
                    state_next = S_PROD;
                end else if (advance) begin
                    state_next = (sp_reg != '0) ? S_PROD : S_END;
                end
            end
            S_END: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Pending right halves, deepest on top.
    always_ff @(posedge aclk) begin
        if (split) begin
            stack_mem[push_idx] <= right_piece;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            sp_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (m_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (q_pop) begin
                if (q_cmd.op == OP_EMIT) begin
                    m_x_reg     <= q_cmd.p0.x;
                    m_y_reg     <= q_cmd.p0.y;
                    m_kind_reg  <= q_cmd.kind;
                    m_last_reg  <= 1'b1;
                end else begin
                    piece_reg.p0    <= q_cmd.p0;
                    piece_reg.p1    <= q_cmd.p1;
                    piece_reg.p2    <= q_cmd.p2;
                    piece_reg.p3    <= q_cmd.p3;
                    piece_reg.level <= '0;
                    is_cubic_reg    <= (q_cmd.op == OP_CUBIC);
                    endpt_reg       <= (q_cmd.op == OP_CUBIC) ? q_cmd.p3 : q_cmd.p2;
                    sp_reg          <= '0;
                end
            end
            if (emit_leaf) begin
                m_x_reg     <= leaf_mid.x;
                m_y_reg     <= leaf_mid.y;
                m_kind_reg  <= KIND_POINT;
                m_last_reg  <= 1'b0;
            end
            if (split) begin
                piece_reg <= left_piece;
                sp_reg    <= sp_reg + CNTW'(1);
            end else if (advance && (sp_reg != '0)) begin
                piece_reg <= stack_mem[top_idx];
                sp_reg    <= sp_reg - CNTW'(1);
            end
            if ((state_reg == S_END) && out_free) begin
                m_x_reg     <= endpt_reg.x;
                m_y_reg     <= endpt_reg.y;
                m_kind_reg  <= KIND_POINT;
                m_last_reg  <= 1'b1;
            end
        end
    end

    // Flatness arithmetic registers.
    always_ff @(posedge aclk) begin
        if (state_reg == S_PROD) begin
            pa1_reg <= u1x * vy;
            pb1_reg <= u1y * vx;
            pa2_reg <= u2x * vy;
            pb2_reg <= u2y * vx;
            sqx_reg <= vx * vx;
            sqy_reg <= vy * vy;
        end
        if (state_reg == S_PART) begin
            in_range_reg <= (dist_sum[DIST_WIDTH-1:FLAT_LIMIT_BITS] == '0);
            ll_reg       <= d_lo * d_lo;
            hl_reg       <= d_hi * d_lo;
            hh_reg       <= d_hi * d_hi;
            rl_reg       <= len[SPLIT_LO-1:0] * tolerance;
            rh_reg       <= len[LEN_WIDTH-1:SPLIT_LO] * tolerance;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_out_x = m_x_reg;
    assign m_out_y = m_y_reg;
    assign m_kind  = m_kind_reg;
    assign m_last  = m_last_reg;

    // The stack never holds more halves than there are levels.
    `BPF_ASSERT_NOW(a_stack_bound, aclk, aresetn, 1'b1, sp_reg <= CNTW'(MAX_DEPTH), "split stack overflow")
    // A curve ends only after every pending half has been flattened.
    `BPF_ASSERT_NOW(a_end_empty, aclk, aresetn, state_reg == S_END, sp_reg == '0, "endpoint with pieces pending")
    // A split always leaves the left half one level deeper.
    `BPF_ASSERT_NEXT(a_split_level, aclk, aresetn, split, piece_reg.level == $past(piece_reg.level) + LVW'(1), "split level mismatch")

endmodule

// ----- rtl/bezier_path_flattener.sv -----
// Flattens move, line, quadratic and cubic path commands into polyline points. A front end
// tracks the current point and classifies each transaction; a two-entry queue decouples it
// from a subdivision engine that splits curves at midpoints, tests each piece with a shared
// flatness unit, and keeps pending halves on a stack of MAX_DEPTH entries. A move or line
// passes from the queue straight into the output register. Each tested piece of a curve goes
// through the product, partial-product and decide states, and the curve ends with its
// endpoint; a busy output can hold the engine until it is free. A line to the current point
// is dropped by the front end and never enters the queue.
module bezier_path_flattener
    import bpf_pkg::*;
#(
    parameter int MAX_DEPTH = DEFAULT_MAX_DEPTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [TOL_WIDTH-1:0]          cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_action,
    input  logic signed [COORD_WIDTH-1:0] s_ax,
    input  logic signed [COORD_WIDTH-1:0] s_ay,
    input  logic signed [COORD_WIDTH-1:0] s_bx,
    input  logic signed [COORD_WIDTH-1:0] s_by,
    input  logic signed [COORD_WIDTH-1:0] s_cx,
    input  logic signed [COORD_WIDTH-1:0] s_cy,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [COORD_WIDTH-1:0] m_out_x,
    output logic signed [COORD_WIDTH-1:0] m_out_y,
    output logic [1:0]                    m_kind,
    output logic                          m_last
);

    logic [TOL_WIDTH-1:0] tolerance_reg;
    logic                 push_valid, push_ready, q_valid, q_pop;
    cmd_t                 push_cmd, q_cmd;

    // Flatness tolerance register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tolerance_reg <= TOL_RESET;
        end else if (cfg_we) begin
            tolerance_reg <= cfg_wdata;
        end
    end

    bpf_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_action   (s_action),
        .s_ax       (s_ax),
        .s_ay       (s_ay),
        .s_bx       (s_bx),
        .s_by       (s_by),
        .s_cx       (s_cx),
        .s_cy       (s_cy),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    bpf_cmd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_cmd    (push_cmd),
        .out_valid (q_valid),
        .out_pop   (q_pop),
        .out_cmd   (q_cmd)
    );

    bpf_engine #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_cmd     (q_cmd),
        .tolerance (tolerance_reg),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_out_x   (m_out_x),
        .m_out_y   (m_out_y),
        .m_kind    (m_kind),
        .m_last    (m_last)
    );

endmodule
